[design/newton_cubic_fractal_iterate_unit_defines.svh]
// ----------------------------------------------------------------------------
// Newton cubic fractal assertion macros
// Shared concurrent assertion forms clocked on i_clk and gated by reset.
// ----------------------------------------------------------------------------
`ifndef NEWTON_CUBIC_FRACTAL_ITERATE_UNIT_DEFINES_SVH
`define NEWTON_CUBIC_FRACTAL_ITERATE_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NCF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NCF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/ncf_pkg.sv]
// ----------------------------------------------------------------------------
// Newton cubic fractal package
// Sequencer states, register indexes and fixed datapath constants.
// ----------------------------------------------------------------------------
package ncf_pkg;

    localparam int MUL_W  = 33;
    localparam int PROD_W = 66;
    localparam int DATA_W = 32;

    localparam logic CFG_MAX_ITER = 1'b0;
    localparam logic CFG_NEAR_THR = 1'b1;

    localparam logic [DATA_W-1:0] THIRD_RECIP = 32'hAAAA_AAAB;
    localparam logic [DATA_W:0]   Q_SAT       = 33'h1_0000_0000 >> 1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHK,
        S_MUL_XX,
        S_MUL_YY,
        S_MUL_XY,
        S_SUM,
        S_MUL_MS,
        S_DEN,
        S_DRE_GO,
        S_DRE_WAIT,
        S_DIM_GO,
        S_DIM_WAIT,
        S_MUL_KX,
        S_MUL_KY,
        S_UPD1,
        S_UPD2,
        S_UPD3,
        S_NEAR_XX,
        S_NEAR_YY,
        S_NEAR_CMP,
        S_FIN
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

[design/ncf_mul.sv]
// ----------------------------------------------------------------------------
// Newton cubic fractal multiplier
// Shared signed 33 by 33 bit multiplier with a registered product.
// ----------------------------------------------------------------------------
module ncf_mul (
    input  logic                                i_clk,
    input  logic signed [ncf_pkg::MUL_W-1:0]    i_a,
    input  logic signed [ncf_pkg::MUL_W-1:0]    i_b,
    output logic signed [ncf_pkg::PROD_W-1:0]   o_prod
);

    logic signed [ncf_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

[design/ncf_div.sv]
// ----------------------------------------------------------------------------
// Newton cubic fractal divider
// Restoring divider, one quotient bit per cycle, saturating fixed-point result.
// ----------------------------------------------------------------------------
module ncf_div #(
    parameter int FRAC_BITS = 28,
    parameter int MAG_W     = 36,
    parameter int DEN_W     = 38
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_neg,
    input  logic [MAG_W-1:0]              i_mag,
    input  logic [DEN_W-1:0]              i_den,
    output ncf_pkg::t_div_stat            o_stat,
    output logic signed [ncf_pkg::DATA_W:0] o_quot
);

    localparam int DIVD_W = MAG_W + FRAC_BITS;
    localparam int CNT_W  = $clog2(DIVD_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIVD_W-1:0] r_acc;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic              r_neg;
    logic              r_zero;

    logic [DEN_W:0]    w_trial;
    logic              w_ge;
    logic [DEN_W:0]    w_diff;
    logic [DEN_W-1:0]  n_rem;
    logic [ncf_pkg::DATA_W:0] w_qmag;

    always_comb begin
        w_trial = {r_rem, r_acc[DIVD_W-1]};
        w_ge    = w_trial >= {1'b0, r_den};
        w_diff  = w_trial - {1'b0, r_den};
        n_rem   = w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc  <= {i_mag, {FRAC_BITS{1'b0}}};
            r_rem  <= '0;
            r_den  <= i_den;
            r_neg  <= i_neg;
            r_zero <= (i_mag == '0);
        end else if (r_busy) begin
            r_acc <= {r_acc[DIVD_W-2:0], w_ge};
            r_rem <= n_rem;
        end
    end

    always_comb begin
        if (r_zero) begin
            w_qmag = '0;
        end else if (r_acc > DIVD_W'(ncf_pkg::Q_SAT)) begin
            w_qmag = ncf_pkg::Q_SAT;
        end else begin
            w_qmag = (ncf_pkg::DATA_W + 1)'(r_acc);
        end
        o_quot = r_neg ? -$signed(w_qmag) : $signed(w_qmag);
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

[design/newton_cubic_fractal_iterate_unit.sv]
// ----------------------------------------------------------------------------
// Newton cubic fractal iterate unit
// Runs Newton's method for z^3+1 on one start point per transfer and reports
// the last iteration at which |z|^2 fell below the near threshold.
// ----------------------------------------------------------------------------
// The unit works on one point at a time and holds off new input until the
// current point is finished. An iteration uses eight steps on the shared
// multiplier, a handful of update steps and two divisions on the bit-serial
// divider, which sets the pace. An iteration that starts at exactly zero
// skips the multiplies and divisions and goes straight to the near check.
// The result sits in an output register, so the next point can start while
// the previous result waits.
// ----------------------------------------------------------------------------
`include "newton_cubic_fractal_iterate_unit_defines.svh"

module newton_cubic_fractal_iterate_unit #(
    parameter int FRAC_BITS  = 28,
    parameter int ITER_WIDTH = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_idx,
    input  logic [ncf_pkg::DATA_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [ncf_pkg::DATA_W-1:0] i_start_re,
    input  logic signed [ncf_pkg::DATA_W-1:0] i_start_im,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [ITER_WIDTH-1:0]             o_last_near_iter,
    output logic                              o_zero_hit
);

    localparam int DW     = ncf_pkg::DATA_W;
    localparam int PW     = ncf_pkg::PROD_W;
    localparam int MW     = ncf_pkg::MUL_W;
    localparam int SW     = 64 - FRAC_BITS;
    localparam int NUM_W  = SW + 1;
    localparam int DEN_W  = 66 - FRAC_BITS;

    function automatic logic signed [SW-1:0] f_trunc(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] b;
        b = p + $signed({{(PW - FRAC_BITS){1'b0}}, {FRAC_BITS{p[PW-1]}}});
        return SW'(b >>> FRAC_BITS);
    endfunction

    function automatic logic [DW-1:0] f_abs(input logic signed [DW-1:0] v);
        return v[DW-1] ? DW'(-v) : DW'(v);
    endfunction

    function automatic logic signed [DW:0] f_two_thirds(input logic signed [DW-1:0] v,
                                                        input logic [DW-1:0] k);
        logic [DW-1:0] a;
        logic [DW-1:0] r;
        logic [DW:0]   t;
        a = f_abs(v);
        r = a - (k + {k[DW-2:0], 1'b0});
        t = {k, 1'b0} + {{DW{1'b0}}, r[1]};
        return v[DW-1] ? -$signed(t) : $signed(t);
    endfunction

    function automatic logic signed [DW-1:0] f_clamp(input logic signed [DW+1:0] v);
        logic signed [DW+1:0] hi;
        logic signed [DW+1:0] lo;
        hi = (DW + 2)'(2147483647);
        lo = -(DW + 2)'(2147483647) - 1'b1;
        if (v > hi) begin
            return DW'(hi);
        end else if (v < lo) begin
            return DW'(lo);
        end
        return DW'(v);
    endfunction

    ncf_pkg::t_state r_state;
    ncf_pkg::t_state n_state;

    logic [ITER_WIDTH-1:0] r_max_iter;
    logic [DW-1:0]         r_near_thr;

    logic signed [DW-1:0]  r_x;
    logic signed [DW-1:0]  r_y;
    logic [ITER_WIDTH-1:0] r_iter;
    logic [ITER_WIDTH-1:0] r_last;
    logic                  r_hit;
    logic signed [SW-1:0]  r_xx;
    logic signed [SW-1:0]  r_yy;
    logic signed [SW-1:0]  r_xy;
    logic [DW-1:0]         r_ms;
    logic [DEN_W-1:0]      r_den;
    logic signed [DW:0]    r_tre;
    logic signed [DW:0]    r_tim;
    logic [DW-1:0]         r_kx;
    logic [DW-1:0]         r_ky;
    logic signed [DW:0]    r_tx;
    logic signed [DW:0]    r_ty;

    logic                  r_out_valid;
    logic [ITER_WIDTH-1:0] r_out_last;
    logic                  r_out_hit;

    logic signed [MW-1:0]  w_mul_a;
    logic signed [MW-1:0]  w_mul_b;
    logic signed [PW-1:0]  w_prod;

    logic                  w_div_start;
    logic signed [NUM_W-1:0] w_num;
    logic                  w_div_neg;
    logic [SW-1:0]         w_div_mag;
    ncf_pkg::t_div_stat    w_div_stat;
    logic signed [DW:0]    w_quot;

    logic                  w_in_xfer;
    logic signed [NUM_W-1:0] w_sum;
    logic [63:0]           w_sum64;
    logic [PW-1:0]         w_den_sh;
    logic signed [DW:0]    w_kx_ops;
    logic signed [NUM_W-1:0] w_mag2;

    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ncf_pkg::S_IDLE);

    ncf_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    ncf_div #(
        .FRAC_BITS (FRAC_BITS),
        .MAG_W     (SW),
        .DEN_W     (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_neg   (w_div_neg),
        .i_mag   (w_div_mag),
        .i_den   (r_den),
        .o_stat  (w_div_stat),
        .o_quot  (w_quot)
    );

    always_comb begin
        n_state     = r_state;
        w_mul_a     = '0;
        w_mul_b     = '0;
        w_div_start = 1'b0;
        w_num       = '0;
        case (r_state)
            ncf_pkg::S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = ncf_pkg::S_CHK;
                end
            end
            ncf_pkg::S_CHK: begin
                if (r_iter >= r_max_iter) begin
                    n_state = ncf_pkg::S_FIN;
                end else if (r_x == '0 && r_y == '0) begin
                    n_state = ncf_pkg::S_NEAR_XX;
                end else begin
                    n_state = ncf_pkg::S_MUL_XX;
                end
            end
            ncf_pkg::S_MUL_XX: begin
                w_mul_a = MW'(r_x);
                w_mul_b = MW'(r_x);
                n_state = ncf_pkg::S_MUL_YY;
            end
            ncf_pkg::S_MUL_YY: begin
                w_mul_a = MW'(r_y);
                w_mul_b = MW'(r_y);
                n_state = ncf_pkg::S_MUL_XY;
            end
            ncf_pkg::S_MUL_XY: begin
                w_mul_a = MW'(r_x);
                w_mul_b = MW'(r_y);
                n_state = ncf_pkg::S_SUM;
            end
            ncf_pkg::S_SUM: begin
                n_state = ncf_pkg::S_MUL_MS;
            end
            ncf_pkg::S_MUL_MS: begin
                w_mul_a = $signed({1'b0, r_ms});
                w_mul_b = $signed({1'b0, r_ms});
                n_state = ncf_pkg::S_DEN;
            end
            ncf_pkg::S_DEN: begin
                n_state = ncf_pkg::S_DRE_GO;
            end
            ncf_pkg::S_DRE_GO: begin
                w_num       = NUM_W'(r_xx) - NUM_W'(r_yy);
                w_div_start = 1'b1;
                n_state     = ncf_pkg::S_DRE_WAIT;
            end
            ncf_pkg::S_DRE_WAIT: begin
                if (w_div_stat.done) begin
                    n_state = ncf_pkg::S_DIM_GO;
                end
            end
            ncf_pkg::S_DIM_GO: begin
                w_num       = $signed({r_xy, 1'b0});
                w_div_start = 1'b1;
                n_state     = ncf_pkg::S_DIM_WAIT;
            end
            ncf_pkg::S_DIM_WAIT: begin
                if (w_div_stat.done) begin
                    n_state = ncf_pkg::S_MUL_KX;
                end
            end
            ncf_pkg::S_MUL_KX: begin
                w_mul_a = $signed({1'b0, f_abs(r_x)});
                w_mul_b = $signed({1'b0, ncf_pkg::THIRD_RECIP});
                n_state = ncf_pkg::S_MUL_KY;
            end
            ncf_pkg::S_MUL_KY: begin
                w_mul_a = $signed({1'b0, f_abs(r_y)});
                w_mul_b = $signed({1'b0, ncf_pkg::THIRD_RECIP});
                n_state = ncf_pkg::S_UPD1;
            end
            ncf_pkg::S_UPD1: begin
                n_state = ncf_pkg::S_UPD2;
            end
            ncf_pkg::S_UPD2: begin
                n_state = ncf_pkg::S_UPD3;
            end
            ncf_pkg::S_UPD3: begin
                n_state = ncf_pkg::S_NEAR_XX;
            end
            ncf_pkg::S_NEAR_XX: begin
                w_mul_a = MW'(r_x);
                w_mul_b = MW'(r_x);
                n_state = ncf_pkg::S_NEAR_YY;
            end
            ncf_pkg::S_NEAR_YY: begin
                w_mul_a = MW'(r_y);
                w_mul_b = MW'(r_y);
                n_state = ncf_pkg::S_NEAR_CMP;
            end
            ncf_pkg::S_NEAR_CMP: begin
                n_state = ncf_pkg::S_CHK;
            end
            ncf_pkg::S_FIN: begin
                if (!r_out_valid) begin
                    n_state = ncf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ncf_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        w_div_neg = w_num[NUM_W-1];
        w_div_mag = w_div_neg ? SW'(-w_num) : SW'(w_num);
        w_sum     = NUM_W'(r_xx) + NUM_W'(r_yy);
        w_sum64   = 64'(w_sum);
        w_den_sh  = PW'(w_prod) >> FRAC_BITS;
        w_kx_ops  = f_two_thirds(r_x, r_kx);
        w_mag2    = NUM_W'(r_xx) + NUM_W'(f_trunc(w_prod));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ncf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= ITER_WIDTH'(64);
            r_near_thr <= DW'(268435);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ncf_pkg::CFG_MAX_ITER: r_max_iter <= i_cfg_data[ITER_WIDTH-1:0];
                ncf_pkg::CFG_NEAR_THR: r_near_thr <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ncf_pkg::S_FIN && !r_out_valid) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ncf_pkg::S_IDLE: begin
                if (w_in_xfer) begin
                    r_x    <= i_start_re;
                    r_y    <= i_start_im;
                    r_iter <= ITER_WIDTH'(1);
                    r_last <= '0;
                    r_hit  <= 1'b0;
                end
            end
            ncf_pkg::S_CHK: begin
                if (r_iter < r_max_iter && r_x == '0 && r_y == '0) begin
                    r_hit <= 1'b1;
                end
            end
            ncf_pkg::S_MUL_YY:   r_xx <= f_trunc(w_prod);
            ncf_pkg::S_MUL_XY:   r_yy <= f_trunc(w_prod);
            ncf_pkg::S_SUM: begin
                r_xy <= f_trunc(w_prod);
                r_ms <= (w_sum64 > 64'hFFFF_FFFF) ? '1 : w_sum64[DW-1:0];
            end
            ncf_pkg::S_DEN:      r_den <= DEN_W'(w_den_sh + (w_den_sh << 1));
            ncf_pkg::S_DRE_WAIT: r_tre <= w_quot;
            ncf_pkg::S_DIM_WAIT: r_tim <= w_quot;
            ncf_pkg::S_MUL_KY:   r_kx <= w_prod[64:33];
            ncf_pkg::S_UPD1: begin
                r_ky <= w_prod[64:33];
                r_tx <= w_kx_ops;
            end
            ncf_pkg::S_UPD2: begin
                r_ty <= f_two_thirds(r_y, r_ky);
                r_x  <= f_clamp((DW + 2)'(r_tx) - (DW + 2)'(r_tre));
            end
            ncf_pkg::S_UPD3:     r_y <= f_clamp((DW + 2)'(r_ty) + (DW + 2)'(r_tim));
            ncf_pkg::S_NEAR_YY:  r_xx <= f_trunc(w_prod);
            ncf_pkg::S_NEAR_CMP: begin
                if (64'(w_mag2) < 64'(r_near_thr)) begin
                    r_last <= r_iter;
                end
                r_iter <= r_iter + 1'b1;
            end
            ncf_pkg::S_FIN: begin
                if (!r_out_valid) begin
                    r_out_last <= r_last;
                    r_out_hit  <= r_hit;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid      = r_out_valid;
    assign o_last_near_iter = r_out_last;
    assign o_zero_hit       = r_out_hit;

    `NCF_ASSERT_SAME(a_div_busy_in_wait, w_div_stat.busy,
        (r_state == ncf_pkg::S_DRE_WAIT || r_state == ncf_pkg::S_DIM_WAIT),
        "divider busy outside a wait state")
    `NCF_ASSERT_SAME(a_iter_in_range, r_state == ncf_pkg::S_MUL_XX,
        r_iter < r_max_iter, "iteration started past the loop bound")
    `NCF_ASSERT_NEXT(a_accept_leaves_idle, w_in_xfer, r_state == ncf_pkg::S_CHK,
        "input transfer did not start a point")

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// Newton cubic fractal iterate unit testbench
// Sends start points through the valid/stall input channel and checks each
// result transfer against an in-bench fixed-point model of the iteration.
// Covers register extremes, the zero-point and underflow cases, and random
// points under random idling and long output back-pressure.
// ----------------------------------------------------------------------------
module testbench;

    localparam int FRAC   = 28;
    localparam int ITER_W = 12;
    localparam int WATCHDOG_LIMIT = 100000;
    localparam logic signed [31:0] Q_ONE = 32'sh1000_0000;

    typedef struct {
        logic [ITER_W-1:0] last_near_iter;
        logic              zero_hit;
    } t_pixel_result;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_cfg_we;
    logic                              i_cfg_idx;
    logic [ncf_pkg::DATA_W-1:0]        i_cfg_data;
    logic                              i_in_valid;
    logic                              o_in_stall;
    logic signed [ncf_pkg::DATA_W-1:0] i_start_re;
    logic signed [ncf_pkg::DATA_W-1:0] i_start_im;
    logic                              o_out_valid;
    logic                              i_out_stall;
    logic [ITER_W-1:0]                 o_last_near_iter;
    logic                              o_zero_hit;

    t_pixel_result pending_results[$];
    logic [ITER_W-1:0] iter_limit;
    logic [31:0]       near_limit;
    int errors;
    int idle_cycles;
    int rx_hold_cycles;
    bit rx_eager;

    newton_cubic_fractal_iterate_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_start_re       (i_start_re),
        .i_start_im       (i_start_im),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_last_near_iter (o_last_near_iter),
        .o_zero_hit       (o_zero_hit)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint fx_mul(longint a, longint b);
        longint p;
        longint mag;
        p = a * b;
        mag = (p < 0) ? -p : p;
        mag = mag >>> FRAC;
        return (p < 0) ? -mag : mag;
    endfunction

    function automatic longint fx_div(longint n, bit [63:0] d);
        bit [63:0] mag;
        bit [63:0] q;
        bit [63:0] rem;
        bit [63:0] sat;
        sat = 64'd1 << 31;
        mag = (n < 0) ? -n : n;
        if (mag == 0) return 0;
        if (d == 0) begin
            q = sat;
        end else begin
            q = mag / d;
            rem = mag % d;
            if (q > sat) q = sat;
            for (int k = 0; k < FRAC && q < sat; k++) begin
                q = q << 1;
                rem = rem << 1;
                if (rem >= d) begin
                    rem = rem - d;
                    q[0] = 1'b1;
                end
            end
            if (q > sat) q = sat;
        end
        return (n < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clamp_s32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic t_pixel_result newton_predict(logic signed [31:0] re,
                                                     logic signed [31:0] im);
        t_pixel_result r;
        longint x, y, xx, yy, xy, m, mag2;
        bit [63:0] ms, den;
        x = longint'(re);
        y = longint'(im);
        r.last_near_iter = '0;
        r.zero_hit = 1'b0;
        for (int i = 1; i < iter_limit; i++) begin
            if (x == 0 && y == 0) begin
                r.zero_hit = 1'b1;
            end else begin
                xx = fx_mul(x, x);
                yy = fx_mul(y, y);
                xy = fx_mul(x, y);
                m = xx + yy;
                ms = (m > 64'sh0FFFF_FFFF) ? 64'hFFFF_FFFF : m;
                den = 3 * ((ms * ms) >> FRAC);
                x = clamp_s32((2 * x) / 3 - fx_div(xx - yy, den));
                y = clamp_s32((2 * y) / 3 + fx_div(2 * xy, den));
            end
            mag2 = fx_mul(x, x) + fx_mul(y, y);
            if (mag2 < longint'(near_limit)) r.last_near_iter = ITER_W'(i);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            pending_results.push_back(newton_predict(i_start_re, i_start_im));
    end

    always @(posedge i_clk) begin
        t_pixel_result exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result transfer iter=%0d hit=%0b",
                         $time, o_last_near_iter, o_zero_hit);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_last_near_iter !== exp_r.last_near_iter) begin
                    $display("%0t: last_near_iter expected %0d actual %0d",
                             $time, exp_r.last_near_iter, o_last_near_iter);
                    errors++;
                end
                if (o_zero_hit !== exp_r.zero_hit) begin
                    $display("%0t: zero_hit expected %0b actual %0b",
                             $time, exp_r.zero_hit, o_zero_hit);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Receiver: random hold-off before each transfer, with an optional long hold.
    initial begin
        int n;
        i_out_stall <= 1'b0;
        forever begin
            if (rx_hold_cycles > 0) begin
                i_out_stall <= 1'b1;
                repeat (rx_hold_cycles) @(posedge i_clk);
                rx_hold_cycles = 0;
            end
            n = rx_eager ? 0 : $urandom_range(0, 7);
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid && rx_hold_cycles == 0) @(posedge i_clk);
        end
    end

    task automatic write_reg(logic idx, logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == ncf_pkg::CFG_MAX_ITER) iter_limit = data[ITER_W-1:0];
        else near_limit = data;
        @(posedge i_clk);
    endtask

    task automatic send_point(logic signed [31:0] re, logic signed [31:0] im,
                              bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_start_re <= re;
        i_start_im <= im;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] random_point_part(int kind);
        case (kind)
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000;
            default: return $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
        endcase
    endfunction

    task automatic test_directed();
        write_reg(ncf_pkg::CFG_MAX_ITER, 6);
        write_reg(ncf_pkg::CFG_NEAR_THR, 268435);
        send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_point(32'sh8000_0000, 32'sh8000_0000);
        send_point(32'sh7FFF_FFFF, 32'sh8000_0000);
        send_point(0, 0);
        send_point(1, 0);
        send_point(0, -1);
        send_point(32'sh0000_4000, 0);
        send_point(32'sh0000_4000, 32'sh0000_4000);
        send_point(-Q_ONE, 0);
        send_point(Q_ONE / 2, 32'sh0DDB_3D74);
        send_point(Q_ONE / 2, -32'sh0DDB_3D74);
        send_point(Q_ONE, Q_ONE);
        wait_drained();
        write_reg(ncf_pkg::CFG_NEAR_THR, 32'hFFFF_FFFF);
        send_point(Q_ONE / 3, -Q_ONE / 5);
        send_point(0, 0);
        wait_drained();
        write_reg(ncf_pkg::CFG_NEAR_THR, 0);
        send_point(0, 0);
        send_point(-Q_ONE, 0);
        wait_drained();
        write_reg(ncf_pkg::CFG_MAX_ITER, 0);
        send_point(Q_ONE, 0);
        send_point(0, 0);
        wait_drained();
        write_reg(ncf_pkg::CFG_MAX_ITER, 1);
        send_point(Q_ONE, Q_ONE);
        wait_drained();
        write_reg(ncf_pkg::CFG_MAX_ITER, 4095);
        write_reg(ncf_pkg::CFG_NEAR_THR, 1);
        send_point(0, 0);
        wait_drained();
    endtask

    task automatic test_random();
        int kind;
        for (int phase = 0; phase < 6; phase++) begin
            write_reg(ncf_pkg::CFG_MAX_ITER, $urandom_range(2, 10));
            case (phase)
                0: write_reg(ncf_pkg::CFG_NEAR_THR, 268435);
                1: write_reg(ncf_pkg::CFG_NEAR_THR, 32'hFFFF_FFFF);
                2: write_reg(ncf_pkg::CFG_NEAR_THR, 0);
                default: write_reg(ncf_pkg::CFG_NEAR_THR, $urandom_range(0, 32'h2000_0000));
            endcase
            rx_eager = (phase == 3);
            for (int n = 0; n < 20; n++) begin
                kind = $urandom_range(0, 9);
                if (kind == 9) send_point(0, 0, phase == 3);
                else send_point(random_point_part(kind % 3), random_point_part(kind % 3),
                                phase == 3);
            end
            wait_drained();
        end
        rx_eager = 0;
    endtask

    task automatic test_backpressure();
        write_reg(ncf_pkg::CFG_MAX_ITER, 3);
        rx_hold_cycles = 3000;
        for (int n = 0; n < 6; n++)
            send_point(random_point_part(1), random_point_part(1), 1);
        wait_drained();
    endtask

    task automatic test_sender_pause();
        write_reg(ncf_pkg::CFG_MAX_ITER, 4);
        write_reg(ncf_pkg::CFG_NEAR_THR, 32'h0100_0000);
        for (int n = 0; n < 3; n++) send_point(random_point_part(2), random_point_part(2));
        wait_drained();
        for (int n = 0; n < 3; n++) send_point(random_point_part(0), random_point_part(2));
        wait_drained();
    endtask

    initial begin
        errors = 0;
        idle_cycles = 0;
        rx_hold_cycles = 0;
        rx_eager = 0;
        iter_limit = 64;
        near_limit = 268435;
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= ncf_pkg::CFG_MAX_ITER;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_start_re <= '0;
        i_start_im <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_point(Q_ONE / 4, Q_ONE / 8);
        wait_drained();
        test_directed();
        test_random();
        test_backpressure();
        test_sender_pause();
        wait_drained();
        repeat (50) @(posedge i_clk);
        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule
